// File: rtl/core/bcd_pkg.sv
package bcd_pkg;

  localparam int NUM_CHORDS = 4;
  localparam int CNT_W      = 8;

  // scan mode; code 3 never arises and is handled as return
  typedef enum logic [1:0] {
    MODE_COLLECT = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_RETURN  = 2'd2
  } mode_t;

  // active-low line patterns
  localparam logic [2:0] LINES_NONE       = 3'd7;
  localparam logic [2:0] LINES_PREV_NEXT  = 3'd4;
  localparam logic [2:0] LINES_NEXT       = 3'd6;
  localparam logic [2:0] LINES_PREV       = 3'd5;
  localparam logic [2:0] LINES_PLAY_PAUSE = 3'd3;

  // reported event codes
  localparam logic [2:0] EV_NONE       = 3'd0;
  localparam logic [2:0] EV_PREV_NEXT  = 3'd1;
  localparam logic [2:0] EV_NEXT       = 3'd2;
  localparam logic [2:0] EV_PREV       = 3'd3;
  localparam logic [2:0] EV_PLAY_PAUSE = 3'd4;

  // register index (byte address bit 2)
  localparam logic       REG_PRESS_THRESHOLD = 1'b0;
  localparam logic [7:0] THRESHOLD_RESET     = 8'd5;

  typedef struct packed {
    logic [2:0] event_code;
    logic [1:0] phase;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] idx;
  } chord_t;

  function automatic chord_t chord_of(input logic [2:0] lines);
    chord_t c;
    c = '0;
    case (lines)
      LINES_PREV_NEXT: begin
        c.hit = 1'b1; c.idx = 2'd0;
      end
      LINES_NEXT: begin
        c.hit = 1'b1; c.idx = 2'd1;
      end
      LINES_PREV: begin
        c.hit = 1'b1; c.idx = 2'd2;
      end
      LINES_PLAY_PAUSE: begin
        c.hit = 1'b1; c.idx = 2'd3;
      end
      default: begin
        c = '0;
      end
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/button_chord_debouncer.sv
// Channel  | handshake                  | payload
// ---------+----------------------------+---------------------------
// sample   | button_valid/button_ready  | button_lines[2:0]
// result   | event_valid/event_ready    | event_code[2:0], phase[1:0]
// config   | APB (psel/penable/pwrite)  | paddr[2:0], pwdata/prdata[31:0]
//
// One sample word is taken per cycle unless a stalled result holds it; its
// result word is in the output register next cycle. The four chord counters
// and scan mode update at the accept edge; the next sample may follow at once.
// Synchronous active-high reset clears the counters, the mode, the output
// valid and sets press_threshold to 5.
// A stalled result holds the sample side only while the output register is
// full and event_ready is low.
module button_chord_debouncer
  import bcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // APB config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // sample stream
  input  logic        button_valid,
  output logic        button_ready,
  input  logic [2:0]  button_lines,
  // result stream
  output logic        event_valid,
  input  logic        event_ready,
  output logic [2:0]  event_code,
  output logic [1:0]  phase
);

  logic [7:0] press_threshold;
  logic       cfg_write;
  logic       accept;
  result_t    step_result;

  // ---- configuration -------------------------------------------------------
  // Single register at byte address 0; paddr[2] selects it, lower bits ignored.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_threshold <= THRESHOLD_RESET;
    end else if (cfg_write && paddr[2] == REG_PRESS_THRESHOLD) begin
      press_threshold <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_PRESS_THRESHOLD) ? {24'd0, press_threshold} : 32'd0;

  // ---- sample acceptance ---------------------------------------------------
  // Output register empty, or being drained this cycle, frees the input.
  assign button_ready = !event_valid || event_ready;
  assign accept       = button_valid && button_ready;

  bcd_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .lines     (button_lines),
    .threshold (press_threshold),
    .result    (step_result)
  );

  // ---- result register -----------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (accept) begin
      event_valid <= 1'b1;
    end else if (event_ready) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      event_code <= step_result.event_code;
      phase      <= step_result.phase;
    end
  end

`ifndef NO_ASSERTIONS
  // every accepted sample leaves a result word behind
  a_word_out: assert property (@(posedge clk) disable iff (rst)
    accept |=> event_valid)
    else $error("accepted sample produced no result word");

  // a reported chord always moves the block into release
  a_event_release: assert property (@(posedge clk) disable iff (rst)
    event_valid && event_code != EV_NONE |-> phase == 2'(MODE_RELEASE))
    else $error("event reported outside release phase");

  // event codes stay within the chord set
  a_event_range: assert property (@(posedge clk) disable iff (rst)
    event_valid |-> event_code <= EV_PLAY_PAUSE)
    else $error("event code out of range");
`endif

endmodule

// File: rtl/core/bcd_engine.sv
module bcd_engine
  import bcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [2:0] lines,
  input  logic [7:0] threshold,
  output result_t    result
);

  logic [CNT_W-1:0] counters      [NUM_CHORDS];
  logic [CNT_W-1:0] counters_next [NUM_CHORDS];
  logic [CNT_W-1:0] dec_val       [NUM_CHORDS];
  logic [CNT_W-1:0] inc_val;
  mode_t            mode, mode_next;
  chord_t           chord;
  logic             reached;
  logic             any_left;

  assign chord = chord_of(lines);

  // saturating increment of the matched chord
  assign inc_val = (counters[chord.idx] == {CNT_W{1'b1}}) ? counters[chord.idx]
                                                          : counters[chord.idx] + CNT_W'(1);
  assign reached = chord.hit && (inc_val >= threshold);

  always_comb begin
    any_left = 1'b0;
    for (int i = 0; i < NUM_CHORDS; i++) begin
      dec_val[i] = (counters[i] != '0) ? counters[i] - CNT_W'(1) : counters[i];
      any_left   = any_left | (dec_val[i] != '0);
    end
  end

  // counter update
  always_comb begin
    for (int i = 0; i < NUM_CHORDS; i++) begin
      counters_next[i] = counters[i];
    end
    case (mode)
      MODE_COLLECT: begin
        if (chord.hit) begin
          for (int i = 0; i < NUM_CHORDS; i++) begin
            counters_next[i] = (2'(i) == chord.idx) ? inc_val : dec_val[i];
          end
        end
      end
      MODE_RELEASE: begin
        if (lines == LINES_NONE) begin
          for (int i = 0; i < NUM_CHORDS; i++) begin
            counters_next[i] = dec_val[i];
          end
        end
      end
      default: begin
        for (int i = 0; i < NUM_CHORDS; i++) begin
          counters_next[i] = counters[i];
        end
      end
    endcase
  end

  // next mode
  always_comb begin
    mode_next = mode;
    case (mode)
      MODE_COLLECT: begin
        if (reached) mode_next = MODE_RELEASE;
      end
      MODE_RELEASE: begin
        if (lines == LINES_NONE && !any_left) mode_next = MODE_RETURN;
      end
      default: begin
        mode_next = MODE_COLLECT;
      end
    endcase
  end

  // result word
  always_comb begin
    result.event_code = EV_NONE;
    if (mode == MODE_COLLECT && reached) begin
      result.event_code = 3'({1'b0, chord.idx}) + 3'd1;
    end
    result.phase = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_COLLECT;
      for (int i = 0; i < NUM_CHORDS; i++) begin
        counters[i] <= '0;
      end
    end else if (step) begin
      mode <= mode_next;
      for (int i = 0; i < NUM_CHORDS; i++) begin
        counters[i] <= counters_next[i];
      end
    end
  end

`ifndef NO_ASSERTIONS
  // return lasts exactly one sample
  a_return_one_step: assert property (@(posedge clk) disable iff (rst)
    step && mode == MODE_RETURN |=> mode == MODE_COLLECT)
    else $error("return mode did not fall back to collect");

  // return is only entered with every counter drained
  a_return_drained: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_RETURN |-> (counters[0] == '0 && counters[1] == '0 &&
                             counters[2] == '0 && counters[3] == '0))
    else $error("return mode with a nonzero counter");

  // the unused mode code never shows up
  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_COLLECT || mode == MODE_RELEASE || mode == MODE_RETURN)
    else $error("scan mode holds an unused code");
`endif

endmodule

// File: tb/button_chord_debouncer_tb.sv
module button_chord_debouncer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bcd_pkg::*;

  // no-progress limit in cycles; a correct run idles only during a sender gap,
  // a sink stall or a config access
  localparam int WATCHDOG_LIMIT = 1000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        button_valid = 1'b0;
  logic        button_ready;
  logic [2:0]  button_lines = LINES_NONE;
  logic        event_valid;
  logic        event_ready = 1'b0;
  logic [2:0]  event_code;
  logic [1:0]  phase;

  // predictor state: its own copy of counters, mode and threshold
  logic [7:0]  chord_count [NUM_CHORDS];
  mode_t       chord_mode;
  logic [7:0]  threshold_now;

  result_t     expected_words [$];
  int          mismatches = 0;
  int          lines_sent = 0;
  int          idle_cycles = 0;
  bit          feed_calm = 1'b0;
  bit          sink_calm = 1'b0;

  button_chord_debouncer DUT (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .button_valid (button_valid),
    .button_ready (button_ready),
    .button_lines (button_lines),
    .event_valid  (event_valid),
    .event_ready  (event_ready),
    .event_code   (event_code),
    .phase        (phase)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    end
  endfunction

  // One sample tick of the debouncer. Updates the predictor state and
  // returns the word the block should emit for it.
  function automatic result_t debounce_step(input logic [2:0] lines);
    result_t     r;
    logic [2:0]  ev;
    int          hit;
    logic        still_held;
    r = '0;
    ev = EV_NONE;
    hit = -1;
    still_held = 1'b0;
    case (chord_mode)
      MODE_COLLECT: begin
        case (lines)
          LINES_PREV_NEXT:  ev = EV_PREV_NEXT;
          LINES_NEXT:       ev = EV_NEXT;
          LINES_PREV:       ev = EV_PREV;
          LINES_PLAY_PAUSE: ev = EV_PLAY_PAUSE;
          default:          ev = EV_NONE;
        endcase
        if (ev != EV_NONE) begin
          hit = int'(ev) - 1;
          for (int i = 0; i < NUM_CHORDS; i++) begin
            if (i == hit) begin
              // saturates at the top; not reachable while the chord gets reported
              if (chord_count[i] != 8'hFF) chord_count[i] = chord_count[i] + 8'd1;
            end else if (chord_count[i] != 8'd0) begin
              chord_count[i] = chord_count[i] - 8'd1;
            end
          end
          if (chord_count[hit] >= threshold_now) begin
            r.event_code = ev;
            chord_mode = MODE_RELEASE;
          end
        end
      end
      MODE_RELEASE: begin
        // only an all-released sample bleeds the counters down
        if (lines == LINES_NONE) begin
          for (int i = 0; i < NUM_CHORDS; i++) begin
            if (chord_count[i] != 8'd0) chord_count[i] = chord_count[i] - 8'd1;
            if (chord_count[i] != 8'd0) still_held = 1'b1;
          end
          if (!still_held) chord_mode = MODE_RETURN;
        end
      end
      default: begin
        // return (and the impossible code 3): one tick back to collect
        chord_mode = MODE_COLLECT;
      end
    endcase
    r.phase = chord_mode;
    return r;
  endfunction

  // Scoreboard: checks each result word against the oldest expectation,
  // then queues the prediction for a sample word accepted at this edge.
  always @(posedge clk) begin : word_monitor
    result_t want;
    if (!rst) begin
      if (event_valid && event_ready) begin
        if (expected_words.size() == 0) begin
          note_mismatch("unexpected result word", 0, {event_code, phase});
        end else begin
          want = expected_words.pop_front();
          if (event_code !== want.event_code)
            note_mismatch("event_code", want.event_code, event_code);
          if (phase !== want.phase)
            note_mismatch("phase", want.phase, phase);
        end
      end
      if (button_valid && button_ready) expected_words.push_back(debounce_step(button_lines));
    end
  end

  // Watchdog: ends the run after too long without any word moving.
  always @(posedge clk) begin
    if (rst || (button_valid && button_ready) || (event_valid && event_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Result sink: random stall before each word, with calm stretches where
  // ready stays high.
  always begin : result_sink
    int stall;
    @(negedge clk);
    stall = sink_calm ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
    if (stall != 0) begin
      event_ready = 1'b0;
      repeat (stall - 1) @(negedge clk);
      @(negedge clk);
    end
    event_ready = 1'b1;
    do @(posedge clk); while (!(event_valid && event_ready));
  end

  // Offer one sample word after a random gap; returns at the accepting edge
  // with valid still high, so back-to-back words need no gap.
  task automatic send_sample(input logic [2:0] lines);
    int gap;
    gap = feed_calm ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 39) == 0) feed_calm = !feed_calm;
    if (gap != 0) begin
      @(negedge clk);
      button_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    button_valid = 1'b1;
    button_lines = lines;
    do @(posedge clk); while (!button_ready);
    lines_sent++;
  endtask

  // Drop valid and wait for every outstanding result word.
  task automatic drain_results();
    @(negedge clk);
    button_valid = 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = {REG_PRESS_THRESHOLD, 2'b00};
    pwdata = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Threshold write only with the block idle, then read it back.
  task automatic write_threshold(input logic [7:0] value);
    logic [31:0] wdata;
    logic [31:0] rdata;
    drain_results();
    wdata = $urandom;
    wdata[7:0] = value;
    apb_access(1'b1, wdata, rdata);
    threshold_now = value;
    apb_access(1'b0, '0, rdata);
    if (rdata[7:0] !== value) note_mismatch("press_threshold readback", value, rdata[7:0]);
  endtask

  // One press/release episode: hold a chord long enough to report it,
  // then release; roughly one word in ten is noise.
  task automatic send_episode(input int thr);
    logic [2:0] chord;
    int         hold;
    int         rel;
    case ($urandom_range(0, 3))
      0:       chord = LINES_PREV_NEXT;
      1:       chord = LINES_NEXT;
      2:       chord = LINES_PREV;
      default: chord = LINES_PLAY_PAUSE;
    endcase
    hold = thr + thr / 3 + $urandom_range(0, 3);
    rel  = thr + thr / 8 + $urandom_range(0, 3);
    repeat (hold) send_sample(($urandom_range(0, 9) == 0) ? 3'($urandom) : chord);
    repeat (rel) send_sample(($urandom_range(0, 9) == 0) ? 3'($urandom) : LINES_NONE);
    repeat ($urandom_range(0, 2)) send_sample(3'($urandom));
  endtask

  // Reset value of the threshold, then a plain press of next up to it.
  task automatic test_default_threshold();
    logic [31:0] rdata;
    apb_access(1'b0, '0, rdata);
    if (rdata[7:0] !== THRESHOLD_RESET)
      note_mismatch("press_threshold after reset", THRESHOLD_RESET, rdata[7:0]);
    repeat (5) send_sample(LINES_NEXT);
    repeat (5) send_sample(LINES_NONE);
  endtask

  // Release mode ignores everything but all-released; return mode takes
  // any word and goes back to collect.
  task automatic test_release_ignores();
    write_threshold(8'd2);
    repeat (2) send_sample(LINES_PLAY_PAUSE);
    for (int p = 0; p < 7; p++) send_sample(3'(p));
    repeat (2) send_sample(LINES_NONE);
    send_sample(LINES_PREV);
  endtask

  // Threshold zero reports a chord on first sight; non-chord patterns in
  // collect change nothing.
  task automatic test_threshold_zero();
    write_threshold(8'd0);
    send_sample(3'd0);
    send_sample(3'd1);
    send_sample(3'd2);
    send_sample(LINES_NONE);
    send_sample(LINES_PREV_NEXT);
    send_sample(LINES_NONE);
    send_sample(LINES_PREV);
    send_sample(LINES_PREV);
  endtask

  // Mostly well-formed episodes at a random threshold in the given range.
  task automatic test_random_debounce(input int thr_lo, input int thr_hi, input int n_words);
    int target;
    int thr;
    thr = $urandom_range(thr_lo, thr_hi);
    write_threshold(8'(thr));
    target = lines_sent + n_words;
    while (lines_sent < target) send_episode(thr);
  endtask

  // Top of the threshold range: one long hold and the full bleed-down.
  task automatic test_max_threshold();
    write_threshold(8'hFF);
    send_episode(255);
  endtask

  initial begin
    for (int i = 0; i < NUM_CHORDS; i++) chord_count[i] = 8'd0;
    chord_mode = MODE_COLLECT;
    threshold_now = THRESHOLD_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_threshold();
    test_release_ignores();
    test_threshold_zero();
    test_random_debounce(1, 4, 250);
    test_random_debounce(5, 16, 250);
    test_max_threshold();
    test_random_debounce(1, 1, 100);
    test_random_debounce(2, 8, 150);

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/bcd_pkg.sv
rtl/core/bcd_engine.sv
rtl/core/button_chord_debouncer.sv
tb/button_chord_debouncer_tb.sv
